// File: sv/binary_opening_shape_features_top_assert.svh
// Assertion macros shared by the binary opening feature block.
// No dependencies; included by modules that carry concurrent checks.
`ifndef BINARY_OPENING_SHAPE_FEATURES_TOP_ASSERT_SVH
`define BINARY_OPENING_SHAPE_FEATURES_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BOSF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bosf check failed");

// Consequent must hold in the cycle after the antecedent.
`define BOSF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bosf check failed");

`endif

// File: sv/bosf_pkg.sv
// Shared constants, register codes and token types of the opening feature block.
// No dependencies.
package bosf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CFG_W   = 11;
    localparam int IDX_W   = 2;
    localparam int PIX_W   = 8;
    localparam int AREA_W  = 21;
    localparam int COORD_W = 10;
    localparam int PROD_W  = 20;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_THRESHOLD    = 2'd2;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [PIX_W-1:0] RST_THRESHOLD    = 8'd10;

    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic bin;
        logic last;
    } px_t;

    typedef struct packed {
        logic valid;
        logic flush;
        logic value;
    } tok_t;

    typedef struct packed {
        logic valid;
        logic flush;
        logic last;
        logic interior;
    } win_ctl_t;

endpackage

// File: sv/bosf_front.sv
// Front end: binarises accepted pixels and tracks the raster position.
// Depends on bosf_pkg.
module bosf_front import bosf_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear,
    input  logic [$clog2(MAX_WIDTH):0]    w_eff,
    input  logic [$clog2(MAX_HEIGHT):0]   h_eff,
    input  logic [PIX_W-1:0]              threshold,
    input  logic [PIX_W-1:0]              pixel,
    input  logic                          accept,
    output px_t                           px
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          col_end, row_end;

    assign col_end = ({1'b0, col_reg} + (CW+1)'(1)) == w_eff;
    assign row_end = ({1'b0, row_reg} + (RW+1)'(1)) == h_eff;

    assign px.bin  = pixel >= threshold;
    assign px.last = col_end && row_end;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_end) begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end
endmodule

// File: sv/bosf_fifo.sv
// Short queue that decouples the front end from the morphology back end.
// Depends on bosf_pkg.
module bosf_fifo import bosf_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic clear,
    input  logic push,
    input  px_t  push_data,
    input  logic pop,
    output px_t  pop_data,
    output logic full,
    output logic empty
);
    localparam int AW = $clog2(FIFO_DEPTH);

    px_t           mem_reg [FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;

    assign full     = count_reg == (AW+1)'(FIFO_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (AW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end
endmodule

// File: sv/bosf_window.sv
// 3x3 window generator: two-row line buffer, column shift and position tracking.
// Depends on bosf_pkg; instantiated once per morphology stage.
module bosf_window import bosf_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              clear,
    input  logic                              adv,
    input  logic [$clog2(MAX_WIDTH):0]        w_eff,
    input  logic [$clog2(MAX_HEIGHT):0]       h_eff,
    input  tok_t                              tok_in,
    output win_ctl_t                          ctl,
    output logic [8:0]                        win,
    output logic [$clog2(MAX_HEIGHT)-1:0]     row,
    output logic [$clog2(MAX_WIDTH)-1:0]      col
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [1:0]    mem [MAX_WIDTH];
    logic [1:0]    rd_reg;

    logic [CW-1:0] ic_reg, oc_reg;
    logic [1:0]    ir_reg;
    logic [RW-1:0] or_reg;
    logic          done_reg;

    win_ctl_t      b_ctl_reg, c_ctl_reg;
    logic          b_cnt_reg, b_val_reg;
    logic [CW-1:0] b_col_reg, b_ocol_reg, c_ocol_reg;
    logic [RW-1:0] b_orow_reg, c_orow_reg;
    logic [2:0]    top_reg, mid_reg, bot_reg;

    logic          count_tok, pass_tok, emit, last, interior;
    logic          ic_end, oc_end, or_end;

    assign count_tok = tok_in.valid && (!done_reg || !tok_in.flush);
    assign pass_tok  = tok_in.valid && done_reg && tok_in.flush;
    assign emit      = count_tok && ((ir_reg == 2'd2) || (ir_reg == 2'd1 && ic_reg != '0));
    assign ic_end    = ({1'b0, ic_reg} + (CW+1)'(1)) == w_eff;
    assign oc_end    = ({1'b0, oc_reg} + (CW+1)'(1)) == w_eff;
    assign or_end    = ({1'b0, or_reg} + (RW+1)'(1)) == h_eff;
    assign last      = emit && oc_end && or_end;
    assign interior  = (or_reg != '0) && (({1'b0, or_reg} + (RW+1)'(2)) <= h_eff) &&
                       (oc_reg != '0) && (({1'b0, oc_reg} + (CW+1)'(2)) <= w_eff);

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (b_cnt_reg) begin
                mem[b_col_reg] <= {b_val_reg, rd_reg[1]};
            end
            if (b_cnt_reg && b_col_reg == ic_reg) begin
                rd_reg <= {b_val_reg, rd_reg[1]};
            end else begin
                rd_reg <= mem[ic_reg];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_val_reg  <= tok_in.value;
            b_col_reg  <= ic_reg;
            b_ocol_reg <= oc_reg;
            b_orow_reg <= or_reg;
            c_ocol_reg <= b_ocol_reg;
            c_orow_reg <= b_orow_reg;
            if (b_cnt_reg) begin
                top_reg <= {top_reg[1:0], rd_reg[0]};
                mid_reg <= {mid_reg[1:0], rd_reg[1]};
                bot_reg <= {bot_reg[1:0], b_val_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            ic_reg    <= '0;
            ir_reg    <= '0;
            oc_reg    <= '0;
            or_reg    <= '0;
            done_reg  <= 1'b0;
            b_ctl_reg <= '0;
            c_ctl_reg <= '0;
            b_cnt_reg <= 1'b0;
        end else if (adv) begin
            if (count_tok) begin
                if (last) begin
                    ic_reg   <= '0;
                    ir_reg   <= '0;
                    oc_reg   <= '0;
                    or_reg   <= '0;
                    done_reg <= 1'b1;
                end else begin
                    done_reg <= 1'b0;
                    if (ic_end) begin
                        ic_reg <= '0;
                        if (ir_reg != 2'd2) begin
                            ir_reg <= ir_reg + 2'd1;
                        end
                    end else begin
                        ic_reg <= ic_reg + CW'(1);
                    end
                    if (emit) begin
                        if (oc_end) begin
                            oc_reg <= '0;
                            or_reg <= or_reg + RW'(1);
                        end else begin
                            oc_reg <= oc_reg + CW'(1);
                        end
                    end
                end
            end
            b_ctl_reg.valid    <= emit || pass_tok;
            b_ctl_reg.flush    <= pass_tok;
            b_ctl_reg.last     <= last;
            b_ctl_reg.interior <= interior;
            b_cnt_reg          <= count_tok;
            c_ctl_reg          <= b_ctl_reg;
        end
    end

    assign ctl = c_ctl_reg;
    assign win = {bot_reg, mid_reg, top_reg};
    assign row = c_orow_reg;
    assign col = c_ocol_reg;
endmodule

// File: sv/bosf_back.sv
// Back end: drain sequencer, erosion, dilation and edge stages, feature sums and result.
// Depends on bosf_pkg, bosf_window and the assertion macro header.
`include "binary_opening_shape_features_top_assert.svh"
module bosf_back import bosf_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear,
    input  logic [$clog2(MAX_WIDTH):0]    w_eff,
    input  logic [$clog2(MAX_HEIGHT):0]   h_eff,
    input  logic                          fifo_empty,
    input  px_t                           fifo_data,
    output logic                          pop,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [AREA_W-1:0]             m_area,
    output logic [AREA_W-1:0]             m_perimeter,
    output logic [COORD_W-1:0]            m_min_x,
    output logic [COORD_W-1:0]            m_max_x,
    output logic [COORD_W-1:0]            m_min_y,
    output logic [COORD_W-1:0]            m_max_y,
    output logic [PROD_W-1:0]             m_box_product,
    output logic                          m_empty_res
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int FW = $clog2(3 * MAX_WIDTH + 4);

    logic              adv, res_load, edge_hit, open_val;
    logic [FW-1:0]     flush_cnt_reg, flush_len;
    tok_t              src_reg, t2, t3;
    win_ctl_t          c1, c2, c3;
    logic [8:0]        win1, win2, win3;
    logic [RW-1:0]     row2;
    logic [CW-1:0]     col2;

    logic [AREA_W-1:0] area_reg, edge_reg;
    logic [CW-1:0]     min_x_reg, max_x_reg;
    logic [RW-1:0]     min_y_reg, max_y_reg;
    logic              seen_reg;
    logic [CW+RW-1:0]  prod;

    logic              res_valid_reg;
    logic [AREA_W-1:0] res_area_reg, res_perim_reg;
    logic [COORD_W-1:0] res_min_x_reg, res_max_x_reg, res_min_y_reg, res_max_y_reg;
    logic [PROD_W-1:0] res_prod_reg;
    logic              res_empty_reg;

    assign adv       = !(res_valid_reg && !m_ready && c3.valid && !c3.flush && c3.last);
    assign pop       = adv && (flush_cnt_reg == '0) && !fifo_empty;
    assign flush_len = FW'({w_eff, 1'b0}) + FW'(w_eff) + FW'(3);

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            flush_cnt_reg <= '0;
            src_reg       <= '0;
        end else if (adv) begin
            if (flush_cnt_reg != '0) begin
                src_reg       <= '{valid: 1'b1, flush: 1'b1, value: 1'b0};
                flush_cnt_reg <= flush_cnt_reg - FW'(1);
            end else if (!fifo_empty) begin
                src_reg <= '{valid: 1'b1, flush: 1'b0, value: fifo_data.bin};
                if (fifo_data.last) begin
                    flush_cnt_reg <= flush_len;
                end
            end else begin
                src_reg <= '0;
            end
        end
    end

    bosf_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_erode (
        .aclk(aclk), .aresetn(aresetn), .clear(clear), .adv(adv),
        .w_eff(w_eff), .h_eff(h_eff), .tok_in(src_reg),
        .ctl(c1), .win(win1), .row(), .col()
    );

    assign t2.valid = c1.valid;
    assign t2.flush = c1.flush;
    assign t2.value = c1.interior ? (&win1) : win1[4];

    bosf_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dilate (
        .aclk(aclk), .aresetn(aresetn), .clear(clear), .adv(adv),
        .w_eff(w_eff), .h_eff(h_eff), .tok_in(t2),
        .ctl(c2), .win(win2), .row(row2), .col(col2)
    );

    assign open_val = c2.interior ? (|win2) : win2[4];
    assign t3.valid = c2.valid;
    assign t3.flush = c2.flush;
    assign t3.value = open_val;

    bosf_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_edge (
        .aclk(aclk), .aresetn(aresetn), .clear(clear), .adv(adv),
        .w_eff(w_eff), .h_eff(h_eff), .tok_in(t3),
        .ctl(c3), .win(win3), .row(), .col()
    );

    assign edge_hit = c3.valid && !c3.flush && c3.interior && win3[4] &&
                      !(win3[1] && win3[7] && win3[5] && win3[3]);
    assign res_load = adv && c3.valid && !c3.flush && c3.last;
    assign prod     = (CW+RW)'(max_x_reg - min_x_reg) * (CW+RW)'(max_y_reg - min_y_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            area_reg  <= '0;
            edge_reg  <= '0;
            min_x_reg <= CW'(MAX_WIDTH - 1);
            max_x_reg <= '0;
            min_y_reg <= RW'(MAX_HEIGHT - 1);
            max_y_reg <= '0;
            seen_reg  <= 1'b0;
        end else if (res_load) begin
            area_reg  <= '0;
            edge_reg  <= '0;
            min_x_reg <= CW'(MAX_WIDTH - 1);
            max_x_reg <= '0;
            min_y_reg <= RW'(MAX_HEIGHT - 1);
            max_y_reg <= '0;
            seen_reg  <= 1'b0;
        end else if (adv) begin
            if (edge_hit) begin
                edge_reg <= edge_reg + AREA_W'(1);
            end
            if (c2.valid && !c2.flush && open_val) begin
                area_reg <= area_reg + AREA_W'(1);
                seen_reg <= 1'b1;
                if (col2 < min_x_reg) begin
                    min_x_reg <= col2;
                end
                if (col2 > max_x_reg) begin
                    max_x_reg <= col2;
                end
                if (row2 < min_y_reg) begin
                    min_y_reg <= row2;
                end
                if (row2 > max_y_reg) begin
                    max_y_reg <= row2;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_area_reg  <= area_reg;
            res_perim_reg <= edge_reg + (edge_hit ? AREA_W'(1) : AREA_W'(0));
            res_min_x_reg <= seen_reg ? COORD_W'(min_x_reg) : '0;
            res_max_x_reg <= seen_reg ? COORD_W'(max_x_reg) : '0;
            res_min_y_reg <= seen_reg ? COORD_W'(min_y_reg) : '0;
            res_max_y_reg <= seen_reg ? COORD_W'(max_y_reg) : '0;
            res_prod_reg  <= seen_reg ? PROD_W'(prod) : '0;
            res_empty_reg <= !seen_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            res_valid_reg <= 1'b0;
        end else if (res_load) begin
            res_valid_reg <= 1'b1;
        end else if (m_ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = res_valid_reg;
    assign m_area        = res_area_reg;
    assign m_perimeter   = res_perim_reg;
    assign m_min_x       = res_min_x_reg;
    assign m_max_x       = res_max_x_reg;
    assign m_min_y       = res_min_y_reg;
    assign m_max_y       = res_max_y_reg;
    assign m_box_product = res_prod_reg;
    assign m_empty_res   = res_empty_reg;

    `BOSF_ASSERT_NOW(a_no_pop_in_drain, aclk, aresetn, flush_cnt_reg != '0, !pop)
    `BOSF_ASSERT_NEXT(a_drain_after_last, aclk, aresetn, pop && fifo_data.last && !clear, flush_cnt_reg != '0)
    `BOSF_ASSERT_NEXT(a_result_held, aclk, aresetn, res_load && !clear, m_valid)
endmodule

// File: sv/binary_opening_shape_features_top.sv
// Throughput: one pixel per cycle while the queue is not full; after each frame the back end
// drains its three line-buffer stages, while the four-entry queue keeps filling.
// Reset: configuration returns to 640x480, threshold 10; counters and sums clear at once;
// line buffers are not cleared. Any configuration write to one of the three registers restarts the frame.
module binary_opening_shape_features_top import bosf_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [PIX_W-1:0]    s_pixel,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [AREA_W-1:0]   m_area,
    output logic [AREA_W-1:0]   m_perimeter,
    output logic [COORD_W-1:0]  m_min_x,
    output logic [COORD_W-1:0]  m_max_x,
    output logic [COORD_W-1:0]  m_min_y,
    output logic [COORD_W-1:0]  m_max_y,
    output logic [PROD_W-1:0]   m_box_product,
    output logic                m_empty_res
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [PIX_W-1:0] threshold_reg;
    logic [CW:0]      w_eff;
    logic [RW:0]      h_eff;
    logic             clear, push, pop, full, empty;
    px_t              push_data, pop_data;

    assign cfg_ready = 1'b1;
    assign clear     = cfg_valid && (cfg_index == REG_FRAME_WIDTH ||
                                     cfg_index == REG_FRAME_HEIGHT ||
                                     cfg_index == REG_THRESHOLD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            threshold_reg    <= RST_THRESHOLD;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_THRESHOLD:    threshold_reg    <= cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = (CW+1)'(1);
        end else if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = (CW+1)'(MAX_WIDTH);
        end else begin
            w_eff = (CW+1)'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_eff = (RW+1)'(1);
        end else if (32'(frame_height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = (RW+1)'(MAX_HEIGHT);
        end else begin
            h_eff = (RW+1)'(frame_height_reg);
        end
    end

    assign s_ready = !full;
    assign push    = s_valid && s_ready;

    bosf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .aclk(aclk), .aresetn(aresetn), .clear(clear),
        .w_eff(w_eff), .h_eff(h_eff), .threshold(threshold_reg),
        .pixel(s_pixel), .accept(push), .px(push_data)
    );

    bosf_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .clear(clear),
        .push(push), .push_data(push_data),
        .pop(pop), .pop_data(pop_data),
        .full(full), .empty(empty)
    );

    bosf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .aclk(aclk), .aresetn(aresetn), .clear(clear),
        .w_eff(w_eff), .h_eff(h_eff),
        .fifo_empty(empty), .fifo_data(pop_data), .pop(pop),
        .m_ready(m_ready), .m_valid(m_valid),
        .m_area(m_area), .m_perimeter(m_perimeter),
        .m_min_x(m_min_x), .m_max_x(m_max_x),
        .m_min_y(m_min_y), .m_max_y(m_max_y),
        .m_box_product(m_box_product), .m_empty_res(m_empty_res)
    );
endmodule
